// File: hdl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, constants and codes shared by the sync frame parser modules.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam int MAX_PAYLOAD = 32;

	localparam int BYTE_W      = 8;
	localparam int CRC_W       = 16;
	localparam int MSG_LEN_W   = 6;
	localparam int IDX_W       = 5;
	localparam int BIT_CNT_W   = 3;
	localparam int CFG_IDX_W   = 1;

	localparam int CNT_W  = ($clog2(MAX_PAYLOAD + 1) > MSG_LEN_W) ?
		$clog2(MAX_PAYLOAD + 1) : MSG_LEN_W;
	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_ID      = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CRCLO   = 3'd5,
		PH_CRCHI   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		C_IDLE = 2'd0,
		C_CRC  = 2'd1,
		C_RD   = 2'd2,
		C_OUT  = 2'd3
	} ctl_state_t;

	typedef struct packed {
		logic              init;
		logic              feed;
		logic [BYTE_W-1:0] data;
	} crc_ctl_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CRC_W-1:0] crc;
	} crc_sts_t;

endpackage

// File: hdl/sfp_rx_if.sv
// ----------------------------------------------------------------------------
// sfp_rx_if
// Valid/ready channel carrying one received byte per request.
// ----------------------------------------------------------------------------
interface sfp_rx_if;

	logic                      valid;
	logic                      ready;
	logic [sfp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);

endinterface

// File: hdl/sfp_msg_if.sv
// ----------------------------------------------------------------------------
// sfp_msg_if
// Valid/ready channel carrying one parsed payload byte per request.
// ----------------------------------------------------------------------------
interface sfp_msg_if;

	logic                          valid;
	logic                          ready;
	logic [sfp_pkg::BYTE_W-1:0]    msg_id;
	logic [sfp_pkg::MSG_LEN_W-1:0] msg_length;
	logic [sfp_pkg::IDX_W-1:0]     byte_index;
	logic [sfp_pkg::BYTE_W-1:0]    payload_byte;
	logic                          last;

	modport source (output valid, output msg_id, output msg_length, output byte_index,
		output payload_byte, output last, input ready);
	modport sink (input valid, input msg_id, input msg_length, input byte_index,
		input payload_byte, input last, output ready);

endinterface

// File: hdl/sfp_ram.sv
// ----------------------------------------------------------------------------
// sfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfp_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              re,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/sfp_crc_unit.sv
// ----------------------------------------------------------------------------
// sfp_crc_unit
// Bit-serial CRC-16 (poly 0x1021, MSB first): folds in one byte, one bit per shift.
// ----------------------------------------------------------------------------
module sfp_crc_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  sfp_pkg::crc_ctl_t ctl,
	output sfp_pkg::crc_sts_t sts
);

	logic [sfp_pkg::CRC_W-1:0]     crc_q;
	logic [sfp_pkg::CRC_W-1:0]     crc_shift;
	logic [sfp_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic                          busy_q;
	logic                          last_bit;

	assign crc_shift = crc_q[sfp_pkg::CRC_W-1] ?
		({crc_q[sfp_pkg::CRC_W-2:0], 1'b0} ^ sfp_pkg::CRC_POLY) :
		{crc_q[sfp_pkg::CRC_W-2:0], 1'b0};
	assign last_bit = (bit_cnt_q == sfp_pkg::BIT_CNT_W'(sfp_pkg::BYTE_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= sfp_pkg::CRC_INIT;
			bit_cnt_q <= '0;
			busy_q    <= 1'b0;
		end else if (ctl.init) begin
			crc_q <= sfp_pkg::CRC_INIT;
		end else if (ctl.feed) begin
			crc_q     <= crc_q ^ {ctl.data, {(sfp_pkg::CRC_W - sfp_pkg::BYTE_W){1'b0}}};
			bit_cnt_q <= '0;
			busy_q    <= 1'b1;
		end else if (busy_q) begin
			crc_q     <= crc_shift;
			bit_cnt_q <= bit_cnt_q + 1'b1;
			if (last_bit) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && last_bit;
	assign sts.crc  = crc_q;

endmodule

// File: hdl/sync_frame_parser_crc16.sv
// ----------------------------------------------------------------------------
// sync_frame_parser_crc16
// Sync/id/length/payload/CRC-16 frame parser, emits payload of good frames.
//
//   channel | dir | requests
//   --------+-----+------------------------------------------------------------
//   rx      | in  | one received byte each
//   msg     | out | one payload byte each, or one empty-frame marker
//   cfg     | in  | write of sync_first (index 0) or sync_second (index 1)
//
// An id, length or payload byte is accepted, then folded in bit by bit by the
// bit-serial CRC unit. Sync and CRC bytes are only accepted, with no CRC shifts.
// A good frame emits each request as a payload RAM read, then output until taken.
// rx is not ready while the CRC unit runs or a frame is being emitted.
// Reset restores sync bytes 0xAA/0x55 and the hunt for the first sync byte.
// ----------------------------------------------------------------------------
module sync_frame_parser_crc16 (
	input  logic                              clk,
	input  logic                              arst_n,
	sfp_rx_if.sink                            rx,
	sfp_msg_if.source                         msg,
	input  logic                              cfg_we,
	input  logic [sfp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [sfp_pkg::BYTE_W-1:0]        cfg_data
);

	logic [sfp_pkg::BYTE_W-1:0] sync_first_q;
	logic [sfp_pkg::BYTE_W-1:0] sync_second_q;

	sfp_pkg::phase_t            phase_q, phase_d;
	sfp_pkg::ctl_state_t        ctl_q, ctl_d;
	logic [sfp_pkg::BYTE_W-1:0] id_q, id_d;
	logic [sfp_pkg::CNT_W-1:0]  len_q, len_d;
	logic [sfp_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	logic [sfp_pkg::BYTE_W-1:0] crc_lo_q, crc_lo_d;
	logic [sfp_pkg::CNT_W-1:0]  rd_idx_q;

	sfp_pkg::crc_ctl_t          crc_ctl;
	sfp_pkg::crc_sts_t          crc_sts;

	logic                       rx_acc;
	logic                       msg_acc;
	logic                       frame_ok;
	logic                       len_zero;
	logic                       msg_last;
	logic                       ram_we;
	logic                       ram_re;
	logic [sfp_pkg::BYTE_W-1:0] ram_rdata;

	assign rx_acc   = rx.valid && rx.ready;
	assign msg_acc  = msg.valid && msg.ready;
	assign len_zero = (len_q == '0);
	assign msg_last = len_zero || (sfp_pkg::CNT_W'(rd_idx_q + 1'b1) == len_q);
	assign frame_ok = rx_acc && (phase_q == sfp_pkg::PH_CRCHI) &&
		({rx.rx_byte, crc_lo_q} == crc_sts.crc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= sfp_pkg::SYNC_FIRST_RST;
			sync_second_q <= sfp_pkg::SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				sfp_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				sfp_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d      = phase_q;
		id_d         = id_q;
		len_d        = len_q;
		cnt_d        = cnt_q;
		crc_lo_d     = crc_lo_q;
		crc_ctl.init = 1'b0;
		crc_ctl.feed = 1'b0;
		crc_ctl.data = rx.rx_byte;
		ram_we       = 1'b0;
		if (rx_acc) begin
			case (phase_q)
				sfp_pkg::PH_SYNC2: begin
					if (rx.rx_byte == sync_second_q) begin
						crc_ctl.init = 1'b1;
						phase_d      = sfp_pkg::PH_ID;
					end else begin
						phase_d = sfp_pkg::PH_SYNC1;
					end
				end
				sfp_pkg::PH_ID: begin
					id_d         = rx.rx_byte;
					crc_ctl.feed = 1'b1;
					phase_d      = sfp_pkg::PH_LEN;
				end
				sfp_pkg::PH_LEN: begin
					if (rx.rx_byte <= sfp_pkg::BYTE_W'(sfp_pkg::MAX_PAYLOAD)) begin
						len_d        = sfp_pkg::CNT_W'(rx.rx_byte);
						cnt_d        = '0;
						crc_ctl.feed = 1'b1;
						phase_d      = (rx.rx_byte != '0) ? sfp_pkg::PH_PAYLOAD :
							sfp_pkg::PH_CRCLO;
					end else begin
						id_d         = '0;
						len_d        = '0;
						cnt_d        = '0;
						crc_ctl.init = 1'b1;
						phase_d      = sfp_pkg::PH_SYNC1;
					end
				end
				sfp_pkg::PH_PAYLOAD: begin
					ram_we       = (cnt_q < sfp_pkg::CNT_W'(sfp_pkg::MAX_PAYLOAD));
					crc_ctl.feed = 1'b1;
					cnt_d        = cnt_q + 1'b1;
					if (cnt_d >= len_q) begin
						phase_d = sfp_pkg::PH_CRCLO;
					end
				end
				sfp_pkg::PH_CRCLO: begin
					crc_lo_d = rx.rx_byte;
					phase_d  = sfp_pkg::PH_CRCHI;
				end
				sfp_pkg::PH_CRCHI: begin
					phase_d = sfp_pkg::PH_SYNC1;
				end
				default: begin
					phase_d = (rx.rx_byte == sync_first_q) ? sfp_pkg::PH_SYNC2 :
						sfp_pkg::PH_SYNC1;
				end
			endcase
		end
	end

	always_comb begin
		ctl_d = ctl_q;
		case (ctl_q)
			sfp_pkg::C_IDLE: begin
				if (crc_ctl.feed) begin
					ctl_d = sfp_pkg::C_CRC;
				end else if (frame_ok) begin
					ctl_d = len_zero ? sfp_pkg::C_OUT : sfp_pkg::C_RD;
				end
			end
			sfp_pkg::C_CRC: begin
				if (crc_sts.done) begin
					ctl_d = sfp_pkg::C_IDLE;
				end
			end
			sfp_pkg::C_RD: ctl_d = sfp_pkg::C_OUT;
			sfp_pkg::C_OUT: begin
				if (msg_acc) begin
					ctl_d = msg_last ? sfp_pkg::C_IDLE : sfp_pkg::C_RD;
				end
			end
			default: ctl_d = sfp_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		rx.ready  = (ctl_q == sfp_pkg::C_IDLE);
		msg.valid = (ctl_q == sfp_pkg::C_OUT);
		ram_re    = (ctl_q == sfp_pkg::C_RD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sfp_pkg::PH_SYNC1;
			ctl_q    <= sfp_pkg::C_IDLE;
			id_q     <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			crc_lo_q <= '0;
			rd_idx_q <= '0;
		end else begin
			phase_q  <= phase_d;
			ctl_q    <= ctl_d;
			id_q     <= id_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			crc_lo_q <= crc_lo_d;
			if (frame_ok) begin
				rd_idx_q <= '0;
			end else if (msg_acc && !msg_last) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	sfp_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.sts    (crc_sts)
	);

	sfp_ram #(
		.WIDTH  (sfp_pkg::BYTE_W),
		.DEPTH  (sfp_pkg::MAX_PAYLOAD),
		.ADDR_W (sfp_pkg::ADDR_W)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (cnt_q[sfp_pkg::ADDR_W-1:0]),
		.wr_data (rx.rx_byte),
		.re      (ram_re),
		.rd_addr (rd_idx_q[sfp_pkg::ADDR_W-1:0]),
		.rd_data (ram_rdata)
	);

	assign msg.msg_id       = id_q;
	assign msg.msg_length   = len_q[sfp_pkg::MSG_LEN_W-1:0];
	assign msg.byte_index   = rd_idx_q[sfp_pkg::IDX_W-1:0];
	assign msg.payload_byte = len_zero ? '0 : ram_rdata;
	assign msg.last         = msg_last;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx.ready && msg.valid))
		else $error("rx ready while a result is pending");

	a_crc_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		crc_sts.busy |-> (ctl_q == sfp_pkg::C_CRC))
		else $error("CRC unit busy outside CRC state");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_acc && msg.last) |=> (ctl_q == sfp_pkg::C_IDLE))
		else $error("emission did not end after last result");

	a_crchi_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && (phase_q == sfp_pkg::PH_CRCHI)) |=> (phase_q == sfp_pkg::PH_SYNC1))
		else $error("parser did not return to hunt after CRC");

endmodule
